@@ hw/rtl/ffra_pkg.sv @@
package ffra_pkg;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RESERVE = 1'b1;

  localparam logic CFG_POOL_START = 1'b0;
  localparam logic CFG_POOL_SIZE  = 1'b1;

endpackage

@@ hw/rtl/ffra_table.sv @@
// Region table: one synchronous memory holding {taken, length, base} per entry.
// One write port and one registered read port.
module ffra_table #(
  parameter int AW    = 32,
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IW-1:0]     wr_idx,
  input  logic [2*AW:0]     wr_data,
  input  logic [IW-1:0]     rd_idx,
  output logic [2*AW:0]     rd_data
);
  logic [2*AW:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end
endmodule

@@ hw/rtl/first_fit_region_allocator_unit.sv @@
// First-fit region allocator over a sorted region table kept in two memory banks.
// A rejected request goes from its check straight to the result word, and a no-fit
// search reads every entry first. An allocation runs a first-fit search at one entry
// per cycle, then one copy pass into the other bank; a reservation makes only the copy pass.
// One request at a time; the next can be accepted in the cycle after the result
// word is taken. Reset (synchronous) clears the pool and leaves one free region.
module first_fit_region_allocator_unit #(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_req_addr,
  input  logic [31:0] in_req_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_address,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import ffra_pkg::*;

  localparam int AW = ADDR_WIDTH;
  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int DW = 2 * AW + 1;
  localparam int LW = (AW > 32) ? AW : 32;
  localparam logic [AW-1:0] AMAX = '1;
  localparam logic [CW:0] CMAX1 = (CW+1)'(MAX_REGIONS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2; // first-fit search, one entry per cycle
  localparam logic [2:0] S_SCAN  = 3'd3; // copy pass into the other bank
  localparam logic [2:0] S_PREV  = 3'd4; // emit the entry in front of the new one
  localparam logic [2:0] S_NEW   = 3'd5;
  localparam logic [2:0] S_TAIL  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [1:0] PH_PRE  = 2'd0; // entries below the new base
  localparam logic [1:0] PH_CUT  = 2'd1; // entries overlapped by the new region
  localparam logic [1:0] PH_COPY = 2'd2; // remaining entries copied as they are

  logic [2:0]    st_r, st_nxt;
  logic [AW-1:0] pstart_r, pstart_nxt, psize_r, psize_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          init_r, init_nxt;   // entry 0 comes from the pool registers
  logic          bank_r, bank_nxt;   // live bank; writes go to the other one
  logic          kind_r, kind_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [31:0]   size_r, size_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [AW-1:0] res_r, res_nxt;
  logic [AW-1:0] nb_r, nb_nxt, ne_r, ne_nxt;
  logic [CW-1:0] rp_r, rp_nxt;       // source entry visible on the read port
  logic [CW-1:0] dst_r, dst_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic          havep_r, havep_nxt;
  logic [DW-1:0] p_r, p_nxt;         // held entry just below the new base
  logic          tail_r, tail_nxt;

  logic          wr_en;
  logic [IW-1:0] wr_idx, rd_idx;
  logic [DW-1:0] wr_data, rd_data;
  logic [DW-1:0] rd0, rd1;
  logic          we0, we1;

  ffra_table #(.AW(AW), .DEPTH(MAX_REGIONS), .IW(IW)) u_tab0 (
    .clk, .wr_en(we0), .wr_idx, .wr_data, .rd_idx, .rd_data(rd0));
  ffra_table #(.AW(AW), .DEPTH(MAX_REGIONS), .IW(IW)) u_tab1 (
    .clk, .wr_en(we1), .wr_idx, .wr_data, .rd_idx, .rd_data(rd1));

  assign rd_data = bank_r ? rd1 : rd0;
  assign we0     = wr_en && bank_r;
  assign we1     = wr_en && !bank_r;
  assign wr_idx  = dst_r[IW-1:0];
  assign rd_idx  = rp_nxt[IW-1:0];

  // Last address of a range; length zero or overflow saturate at the top.
  function automatic logic [AW-1:0] last_of(input logic [AW-1:0] b,
                                            input logic [LW-1:0] l);
    logic [LW:0] s;
    s = (LW+1)'(b) + (LW+1)'(l) - (LW+1)'(1);
    if (l == '0 || s > (LW+1)'(AMAX)) return AMAX;
    return s[AW-1:0];
  endfunction

  logic [DW-1:0] cur;
  logic [AW-1:0] cb, cl, ce;
  logic          ct;
  logic [AW-1:0] pb, pl, pe;
  logic          pt;
  logic [AW-1:0] pend, qend, tb, te;
  logic          fits, full;

  always_comb begin
    cur  = init_r ? {1'b0, psize_r, pstart_r} : rd_data;
    cb   = cur[AW-1:0];
    cl   = cur[2*AW-1:AW];
    ct   = cur[2*AW];
    ce   = last_of(cb, LW'(cl));
    pb   = p_r[AW-1:0];
    pl   = p_r[2*AW-1:AW];
    pt   = p_r[2*AW];
    pe   = last_of(pb, LW'(pl));
    pend = last_of(pstart_r, LW'(psize_r));
    qend = last_of(addr_r, LW'(size_r));
    tb   = (addr_r > pstart_r) ? addr_r : pstart_r;
    te   = (qend < pend) ? qend : pend;
    fits = !ct && (cl == '0 || LW'(cl) >= LW'(size_r));
    full = ({1'b0, cnt_r} + (CW+1)'(2)) > CMAX1;
  end

  always_comb begin
    st_nxt = st_r; pstart_nxt = pstart_r; psize_nxt = psize_r; cnt_nxt = cnt_r;
    init_nxt = init_r; bank_nxt = bank_r; kind_nxt = kind_r; addr_nxt = addr_r;
    size_nxt = size_r; status_nxt = status_r; res_nxt = res_r; nb_nxt = nb_r;
    ne_nxt = ne_r; rp_nxt = rp_r; dst_nxt = dst_r; ph_nxt = ph_r;
    havep_nxt = havep_r; p_nxt = p_r; tail_nxt = tail_r;
    wr_en = 1'b0; wr_data = '0;

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;
          addr_nxt = AW'(in_req_addr);
          size_nxt = in_req_size;
          st_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_nxt = '0; rp_nxt = '0; dst_nxt = '0; ph_nxt = PH_PRE;
        havep_nxt = 1'b0; tail_nxt = 1'b0;
        if (size_r == '0) begin
          status_nxt = ST_EMPTY; st_nxt = S_OUT;
        end else if (kind_r == KIND_RESERVE) begin
          if (te < tb) begin
            status_nxt = ST_EMPTY; st_nxt = S_OUT;
          end else if (full) begin
            status_nxt = ST_FULL; st_nxt = S_OUT;
          end else begin
            nb_nxt = tb; ne_nxt = te; res_nxt = tb; status_nxt = ST_DONE;
            st_nxt = S_SCAN;
          end
        end else if (full) begin
          status_nxt = ST_FULL; st_nxt = S_OUT;
        end else begin
          status_nxt = ST_NOFIT; st_nxt = S_FIND;
        end
      end
      S_FIND: begin
        if (rp_r >= cnt_r) begin
          st_nxt = S_OUT;
        end else if (fits) begin
          nb_nxt = cb; ne_nxt = last_of(cb, LW'(size_r)); res_nxt = cb;
          status_nxt = ST_DONE; rp_nxt = '0; st_nxt = S_SCAN;
        end else begin
          rp_nxt = rp_r + CW'(1);
        end
      end
      S_SCAN: begin
        if (ph_r == PH_PRE) begin
          // hold one entry back: it may have to be split by the new region
          if (rp_r < cnt_r && cb < nb_r) begin
            if (havep_r) begin
              wr_en = 1'b1; wr_data = p_r; dst_nxt = dst_r + CW'(1);
            end
            p_nxt = cur; havep_nxt = 1'b1; rp_nxt = rp_r + CW'(1);
          end else begin
            st_nxt = S_PREV;
          end
        end else if (rp_r >= cnt_r) begin
          cnt_nxt = dst_r; bank_nxt = !bank_r; init_nxt = 1'b0; st_nxt = S_OUT;
        end else begin
          rp_nxt = rp_r + CW'(1);
          if (ph_r == PH_COPY || cb > ne_r) begin
            wr_en = 1'b1; wr_data = cur; dst_nxt = dst_r + CW'(1); ph_nxt = PH_COPY;
          end else if (ce > ne_r) begin
            wr_en = 1'b1; wr_data = {ct, ce - ne_r, ne_r + AW'(1)};
            dst_nxt = dst_r + CW'(1); ph_nxt = PH_COPY;
          end
          // otherwise covered entirely: drop
        end
      end
      S_PREV: begin
        st_nxt = S_NEW;
        if (havep_r) begin
          wr_en = 1'b1; dst_nxt = dst_r + CW'(1);
          if (nb_r <= pe) begin
            wr_data = {pt, nb_r - pb, pb}; tail_nxt = (pe > ne_r);
          end else begin
            wr_data = p_r;
          end
        end
      end
      S_NEW: begin
        wr_en = 1'b1; wr_data = {1'b1, ne_r - nb_r + AW'(1), nb_r};
        dst_nxt = dst_r + CW'(1);
        if (tail_r) begin
          st_nxt = S_TAIL;
        end else begin
          st_nxt = S_SCAN; ph_nxt = PH_CUT;
        end
      end
      S_TAIL: begin
        wr_en = 1'b1; wr_data = {pt, pe - ne_r, ne_r + AW'(1)};
        dst_nxt = dst_r + CW'(1); st_nxt = S_SCAN; ph_nxt = PH_COPY;
      end
      S_OUT: begin
        if (out_ready) st_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      if (cfg_index == CFG_POOL_START) pstart_nxt = AW'(cfg_data);
      else psize_nxt = AW'(cfg_data);
      cnt_nxt = CW'(1); init_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pstart_r <= '0; psize_r <= '0; cnt_r <= CW'(1);
      init_r <= 1'b1; bank_r <= 1'b0; kind_r <= 1'b0; addr_r <= '0; size_r <= '0;
      status_r <= ST_DONE; res_r <= '0; nb_r <= '0; ne_r <= '0; rp_r <= '0;
      dst_r <= '0; ph_r <= PH_PRE; havep_r <= 1'b0; p_r <= '0; tail_r <= 1'b0;
    end else begin
      st_r <= st_nxt; pstart_r <= pstart_nxt; psize_r <= psize_nxt; cnt_r <= cnt_nxt;
      init_r <= init_nxt; bank_r <= bank_nxt; kind_r <= kind_nxt; addr_r <= addr_nxt;
      size_r <= size_nxt; status_r <= status_nxt; res_r <= res_nxt; nb_r <= nb_nxt;
      ne_r <= ne_nxt; rp_r <= rp_nxt; dst_r <= dst_nxt; ph_r <= ph_nxt;
      havep_r <= havep_nxt; p_r <= p_nxt; tail_r <= tail_nxt;
    end
  end

  assign in_ready    = (st_r == S_IDLE);
  assign out_valid   = (st_r == S_OUT);
  assign out_status  = status_r;
  assign out_address = (status_r == ST_DONE) ? 32'(res_r) : 32'd0;

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= CW'(MAX_REGIONS))) else $error("region count out of range");
  a_hs: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_address)))
    else $error("result word changed while waiting");
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (dst_r < CW'(MAX_REGIONS))) else $error("table write past end");
`endif
endmodule
